// ===== rtl/page_framebuffer_blit_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Page framebuffer blit engine assertion macros
// Shared assertion shorthands for the blit engine checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_BLIT_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_BLIT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define PFBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while in reset.
`define PFBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pfbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer blit engine package
// Operation codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package pfbe_pkg;

	// Operation codes carried in the request tuser.
	typedef enum logic [2:0] {
		FUNC_CLEAR_ALL  = 3'd0,
		FUNC_FILL       = 3'd1,
		FUNC_CLEAR_AREA = 3'd2,
		FUNC_DRAW       = 3'd3,
		FUNC_READ       = 3'd4
	} func_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_AREA,
		ST_DRAW_LO,
		ST_DRAW_HI,
		ST_READ,
		ST_READ_CAP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	localparam logic [7:0] FILL_PATTERN  = 8'hAA;
	localparam logic [7:0] CLEAR_PATTERN = 8'h00;

	// Stream widths.
	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 8;

	// Internal coordinate widths: columns up to 256, page numbers up to 16,
	// pixel rows up to 128.
	localparam int COL_W = 9;
	localparam int PG_W  = 5;
	localparam int ROW_W = 8;

endpackage

// ===== rtl/page_framebuffer_blit_engine.sv =====
// One request at a time: s_tready is high only in the idle state, entered once the
// result of the previous request is loaded into the output register. The single write
// port of the frame store handles one byte per cycle; clear and fill sweep every byte.
// Reset: asynchronous, active low; afterwards a clearing pass over all
// PAGE_COUNT*COLUMN_COUNT bytes (1024 by default) zeroes the store while
// s_tready stays low.
// ----------------------------------------------------------------------------
// Page framebuffer blit engine
// One-bit display store of pages of column bytes with clear, fill, area
// clear, image byte draw and byte read operations.
// ----------------------------------------------------------------------------
module page_framebuffer_blit_engine #(
	parameter int PAGE_COUNT   = 8,
	parameter int COLUMN_COUNT = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0 up: x[6:0], y[12:7], width[20:13], height[27:21],
	// col_index[34:28], band_index[37:35], pixel_byte[45:38], page[48:46], zero fill.
	input  logic [pfbe_pkg::S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0 up: func[2:0].
	input  logic [pfbe_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0 up: read_data[7:0].
	output logic [pfbe_pkg::M_TDATA_W-1:0] m_tdata,
	// Fields from bit 0 up: clipped[0].
	output logic                           m_tuser
);

	localparam int DEPTH     = PAGE_COUNT * COLUMN_COUNT;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int ROW_COUNT = PAGE_COUNT * 8;

	localparam logic [pfbe_pkg::COL_W-1:0] COL_LIM   = pfbe_pkg::COL_W'(COLUMN_COUNT);
	localparam logic [pfbe_pkg::PG_W-1:0]  PG_LIM    = pfbe_pkg::PG_W'(PAGE_COUNT);
	localparam logic [pfbe_pkg::ROW_W-1:0] ROW_LIM   = pfbe_pkg::ROW_W'(ROW_COUNT);
	localparam logic [ADDR_W-1:0]          LAST_ADDR = ADDR_W'(DEPTH - 1);

	// Byte address of a page and column in the frame store.
	function automatic logic [ADDR_W-1:0] addr_of(input logic [pfbe_pkg::PG_W-1:0] pg,
		input logic [pfbe_pkg::COL_W-1:0] col);
		return ADDR_W'(32'(pg) * COLUMN_COUNT + 32'(col));
	endfunction

	// ------------------------------------------------------------------
	// Request field unpacking.
	// ------------------------------------------------------------------
	logic [2:0] in_func;
	logic [6:0] in_x;
	logic [5:0] in_y;
	logic [7:0] in_width;
	logic [6:0] in_height;
	logic [6:0] in_col_index;
	logic [2:0] in_band_index;
	logic [7:0] in_pixel_byte;
	logic [2:0] in_page;

	assign in_func       = s_tuser[2:0];
	assign in_x          = s_tdata[6:0];
	assign in_y          = s_tdata[12:7];
	assign in_width      = s_tdata[20:13];
	assign in_height     = s_tdata[27:21];
	assign in_col_index  = s_tdata[34:28];
	assign in_band_index = s_tdata[37:35];
	assign in_pixel_byte = s_tdata[45:38];
	assign in_page       = s_tdata[48:46];

	// ------------------------------------------------------------------
	// State and registers.
	// ------------------------------------------------------------------
	pfbe_pkg::state_t state_q, state_d;

	logic [ADDR_W-1:0]          sweep_cnt_q;
	logic [7:0]                 fill_q;
	logic [pfbe_pkg::COL_W-1:0] col_q;     // current column (area, draw, read)
	logic [pfbe_pkg::PG_W-1:0]  pg_q;      // current page (area, draw, read)
	logic [pfbe_pkg::COL_W-1:0] x0_q;      // area first column
	logic [pfbe_pkg::COL_W-1:0] xl_q;      // area last column
	logic [pfbe_pkg::PG_W-1:0]  pgf_q;     // area first page
	logic [pfbe_pkg::PG_W-1:0]  pgl_q;     // area last page
	logic [2:0]                 ylo_q;     // first row bit within the first page
	logic [2:0]                 yhi_q;     // last row bit within the last page
	logic [7:0]                 lo_q;      // draw bits for the landing page
	logic [7:0]                 hi_q;      // draw bits spilled into the next page
	logic [7:0]                 res_data_q;
	logic                       res_clip_q;
	logic                       m_valid_q;
	logic [7:0]                 m_data_q;
	logic                       m_clip_q;

	// Read-modify-write stage: the read was issued last cycle, the memory
	// data arrives now and the merged byte is written back.
	logic              rmw_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        keep_s1;
	logic [7:0]        or_s1;

	// Frame store: one write port, one registered read port.
	logic [7:0]        frame_store_q [DEPTH];
	logic [7:0]        mem_rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;

	// ------------------------------------------------------------------
	// Request decode.
	// ------------------------------------------------------------------
	logic                       accept;
	logic [pfbe_pkg::COL_W-1:0] draw_col;
	logic [pfbe_pkg::COL_W-1:0] area_xsum;
	logic [pfbe_pkg::COL_W-1:0] area_x1;
	logic [pfbe_pkg::ROW_W-1:0] area_ysum;
	logic [pfbe_pkg::ROW_W-1:0] area_y1;
	logic [pfbe_pkg::ROW_W-1:0] area_ylast;
	logic                       area_empty;
	logic                       draw_clip;
	logic                       read_ok;
	logic [15:0]                draw_wide;

	assign s_tready = (state_q == pfbe_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		draw_col   = pfbe_pkg::COL_W'(in_x) + pfbe_pkg::COL_W'(in_col_index);
		draw_clip  = draw_col > (COL_LIM - pfbe_pkg::COL_W'(1));
		draw_wide  = {8'h00, in_pixel_byte} << in_y[2:0];
		area_xsum  = pfbe_pkg::COL_W'(in_x) + pfbe_pkg::COL_W'(in_width);
		area_x1    = (area_xsum > COL_LIM) ? COL_LIM : area_xsum;
		area_ysum  = pfbe_pkg::ROW_W'(in_y) + pfbe_pkg::ROW_W'(in_height);
		area_y1    = (area_ysum > ROW_LIM) ? ROW_LIM : area_ysum;
		area_ylast = area_y1 - pfbe_pkg::ROW_W'(1);
		area_empty = (area_x1 <= pfbe_pkg::COL_W'(in_x)) ||
			(area_y1 <= pfbe_pkg::ROW_W'(in_y));
		read_ok    = (pfbe_pkg::PG_W'(in_page) < PG_LIM) &&
			(pfbe_pkg::COL_W'(in_x) < COL_LIM);
	end

	// ------------------------------------------------------------------
	// Area row mask for the current page: the rows of the rectangle that
	// fall in this page, from the first row bit on the top page to the last
	// row bit on the bottom page.
	// ------------------------------------------------------------------
	logic [7:0] area_mask;
	logic [2:0] mask_lo;
	logic [2:0] mask_hi;

	always_comb begin
		mask_lo = (pg_q == pgf_q) ? ylo_q : 3'd0;
		mask_hi = (pg_q == pgl_q) ? yhi_q : 3'd7;
		for (int i = 0; i < 8; i++) begin
			area_mask[i] = (3'(i) >= mask_lo) && (3'(i) <= mask_hi);
		end
	end

	logic                      area_col_end;
	logic                      area_last;
	logic                      sweep_last;
	logic [pfbe_pkg::PG_W-1:0] pg_next;

	assign area_col_end = (col_q == xl_q);
	assign area_last    = area_col_end && (pg_q == pgl_q);
	assign sweep_last   = (sweep_cnt_q == LAST_ADDR);
	assign pg_next      = pg_q + pfbe_pkg::PG_W'(1);

	// ------------------------------------------------------------------
	// Next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfbe_pkg::ST_INIT: begin
				if (sweep_last) state_d = pfbe_pkg::ST_IDLE;
			end
			pfbe_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_func)
						pfbe_pkg::FUNC_CLEAR_ALL,
						pfbe_pkg::FUNC_FILL: state_d = pfbe_pkg::ST_SWEEP;
						pfbe_pkg::FUNC_CLEAR_AREA: begin
							state_d = area_empty ? pfbe_pkg::ST_DONE : pfbe_pkg::ST_AREA;
						end
						pfbe_pkg::FUNC_DRAW: begin
							state_d = draw_clip ? pfbe_pkg::ST_DONE : pfbe_pkg::ST_DRAW_LO;
						end
						pfbe_pkg::FUNC_READ: begin
							state_d = read_ok ? pfbe_pkg::ST_READ : pfbe_pkg::ST_DONE;
						end
						default: state_d = pfbe_pkg::ST_DONE;
					endcase
				end
			end
			pfbe_pkg::ST_SWEEP: begin
				if (sweep_last) state_d = pfbe_pkg::ST_DONE;
			end
			pfbe_pkg::ST_AREA: begin
				if (area_last) state_d = pfbe_pkg::ST_DRAIN;
			end
			pfbe_pkg::ST_DRAW_LO:  state_d = pfbe_pkg::ST_DRAW_HI;
			pfbe_pkg::ST_DRAW_HI:  state_d = pfbe_pkg::ST_DRAIN;
			pfbe_pkg::ST_READ:     state_d = pfbe_pkg::ST_READ_CAP;
			pfbe_pkg::ST_READ_CAP: state_d = pfbe_pkg::ST_DONE;
			pfbe_pkg::ST_DRAIN:    state_d = pfbe_pkg::ST_DONE;
			pfbe_pkg::ST_DONE: begin
				if (!m_valid_q || m_tready) state_d = pfbe_pkg::ST_IDLE;
			end
			default: state_d = pfbe_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Memory access issue per state.
	// ------------------------------------------------------------------
	logic              iss_rmw;
	logic [ADDR_W-1:0] iss_addr;
	logic [7:0]        iss_keep;
	logic [7:0]        iss_or;
	logic              sweep_we;
	logic              load_out;

	always_comb begin
		iss_rmw  = 1'b0;
		iss_addr = addr_of(pg_q, col_q);
		iss_keep = 8'hFF;
		iss_or   = 8'h00;
		sweep_we = 1'b0;
		mem_re   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			pfbe_pkg::ST_INIT,
			pfbe_pkg::ST_SWEEP: sweep_we = 1'b1;
			pfbe_pkg::ST_AREA: begin
				iss_rmw  = 1'b1;
				iss_keep = ~area_mask;
			end
			pfbe_pkg::ST_DRAW_LO: begin
				iss_rmw = (pg_q < PG_LIM);
				iss_or  = lo_q;
			end
			pfbe_pkg::ST_DRAW_HI: begin
				// A zero shift leaves nothing to spill.
				iss_rmw  = (pg_next < PG_LIM) && (hi_q != 8'h00);
				iss_addr = addr_of(pg_next, col_q);
				iss_or   = hi_q;
			end
			pfbe_pkg::ST_READ: mem_re = 1'b1;
			pfbe_pkg::ST_DONE: load_out = !m_valid_q || m_tready;
			default: ;
		endcase
		if (iss_rmw) mem_re = 1'b1;
	end

	always_comb begin
		if (sweep_we) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_cnt_q;
			mem_wdata = (state_q == pfbe_pkg::ST_INIT) ? pfbe_pkg::CLEAR_PATTERN : fill_q;
		end else begin
			mem_we    = rmw_s1;
			mem_waddr = addr_s1;
			mem_wdata = (mem_rdata_q & keep_s1) | or_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) frame_store_q[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= frame_store_q[iss_addr];
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfbe_pkg::ST_INIT;
			sweep_cnt_q <= '0;
			rmw_s1      <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rmw_s1  <= iss_rmw;
			if (sweep_we) sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + ADDR_W'(1);
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		addr_s1 <= iss_addr;
		keep_s1 <= iss_keep;
		or_s1   <= iss_or;
		if (accept) begin
			res_data_q <= 8'h00;
			res_clip_q <= (in_func == pfbe_pkg::FUNC_DRAW) && draw_clip;
			fill_q     <= (in_func == pfbe_pkg::FUNC_FILL) ? pfbe_pkg::FILL_PATTERN :
				pfbe_pkg::CLEAR_PATTERN;
			lo_q       <= draw_wide[7:0];
			hi_q       <= draw_wide[15:8];
			x0_q       <= pfbe_pkg::COL_W'(in_x);
			xl_q       <= area_x1 - pfbe_pkg::COL_W'(1);
			pgf_q      <= pfbe_pkg::PG_W'(in_y[5:3]);
			pgl_q      <= area_ylast[pfbe_pkg::ROW_W-1:3];
			ylo_q      <= in_y[2:0];
			yhi_q      <= area_ylast[2:0];
			case (in_func)
				pfbe_pkg::FUNC_DRAW: begin
					col_q <= draw_col;
					pg_q  <= pfbe_pkg::PG_W'(in_y[5:3]) + pfbe_pkg::PG_W'(in_band_index);
				end
				pfbe_pkg::FUNC_READ: begin
					col_q <= pfbe_pkg::COL_W'(in_x);
					pg_q  <= pfbe_pkg::PG_W'(in_page);
				end
				default: begin
					col_q <= pfbe_pkg::COL_W'(in_x);
					pg_q  <= pfbe_pkg::PG_W'(in_y[5:3]);
				end
			endcase
		end else if (state_q == pfbe_pkg::ST_AREA) begin
			// Walk columns across a page, then step to the next page.
			if (area_col_end) begin
				col_q <= x0_q;
				pg_q  <= pg_next;
			end else begin
				col_q <= col_q + pfbe_pkg::COL_W'(1);
			end
		end
		if (state_q == pfbe_pkg::ST_READ_CAP) res_data_q <= mem_rdata_q;
		if (load_out) begin
			m_data_q <= res_data_q;
			m_clip_q <= res_clip_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_clip_q;

endmodule

// ===== rtl/pfbe_checker.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer blit engine checker
// Port-level assertions on the blit engine, attached by bind.
// ----------------------------------------------------------------------------
`include "page_framebuffer_blit_engine_defines.svh"

module pfbe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [pfbe_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [pfbe_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pfbe_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	logic s_accept;

	assign s_accept = s_tvalid && s_tready;

	// A waiting request keeps its valid and payload.
	`PFBE_ASSERT_NEXT(a_request_held, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tuser), "waiting request changed")

	// A stalled result keeps its valid and payload.
	`PFBE_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// A dropped draw never carries read data.
	`PFBE_ASSERT_NOW(a_clip_no_data, m_tvalid && m_tuser, m_tdata == '0, "clipped result with nonzero data")

	// The engine works on one request at a time.
	`PFBE_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready, "request accepted while busy")

	// A new result appears only after the engine has been busy.
	`PFBE_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), !$past(s_tready), "result without a request")

endmodule

bind page_framebuffer_blit_engine pfbe_checker u_pfbe_checker (.*);
